[hdl/qte_pkg.sv]
// Shared types and constants of the quaternion to Z-Y'-X'' Euler angle converter.
// No dependencies; every module of the converter refers to this package by scoped names.
package qte_pkg;

    // Fixed internal word sizes.
    localparam int WORK_BITS    = 20;  // quaternion component inside the datapath
    localparam int PROD_BITS    = 40;  // product of two components
    localparam int NORM_BITS    = 41;  // sum of four squares
    localparam int NUM_BITS     = 42;  // signed numerator of a matrix term
    localparam int MAT_FRAC     = 20;  // fraction bits of a matrix term
    localparam int DIVD_BITS    = 61;  // dividend and remainder of the term divider
    localparam int QUO_BITS     = 21;  // quotient magnitude of a matrix term
    localparam int MAT_BITS     = 22;  // signed matrix term
    localparam int SQ_BITS      = 42;  // radicand and root register of the square root
    localparam int SQRT_STEPS   = 21;  // one root bit per step
    localparam int CY_BITS      = 21;  // cy magnitude
    localparam int THRESH_BITS  = 21;  // lock threshold register
    localparam int CORD_BITS    = 34;  // CORDIC vector components
    localparam int CORD_PRESCALE = 8;  // CORDIC inputs are scaled up by this many bits
    localparam int CORDIC_STEPS = 28;
    localparam int ANG_BITS     = 32;  // internal binary angle, a full turn wraps
    localparam int NUM_TERMS    = 7;
    localparam int LANES        = 3;

    localparam logic [THRESH_BITS-1:0] THRESH_RESET = 21'd10;
    localparam logic [ANG_BITS-1:0]    HALF_TURN    = 32'h8000_0000;

    // Matrix term slots; the diagonal terms come first.
    localparam int T_M00 = 0;
    localparam int T_M11 = 1;
    localparam int T_M22 = 2;
    localparam int T_M10 = 3;
    localparam int T_M12 = 4;
    localparam int T_M20 = 5;
    localparam int T_M21 = 6;

    // CORDIC lanes.
    localparam int L_YAW   = 0;
    localparam int L_PITCH = 1;
    localparam int L_ROLL  = 2;

    // Arctangent of 2^-i as a fraction of a full turn (2^32).
    localparam logic [ANG_BITS-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10680862, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
        32'd81, 32'd41, 32'd20, 32'd10, 32'd5
    };

    // State that travels down the divider chain, all seven terms side by side.
    typedef struct packed {
        logic [NORM_BITS-1:0]                  den;
        logic                                  nz;
        logic [NUM_TERMS-1:0]                  neg;
        logic [NUM_TERMS-1:0][DIVD_BITS-1:0]   rem;
        logic [NUM_TERMS-1:0][QUO_BITS-1:0]    quo;
    } div_state_t;

    // State that travels down the square root chain.
    typedef struct packed {
        logic [SQ_BITS-1:0]                    rad;
        logic [SQ_BITS-1:0]                    root;
        logic [NUM_TERMS-1:0][MAT_BITS-1:0]    mat;
    } sqrt_state_t;

    // State that travels down the CORDIC chain, three lanes side by side.
    typedef struct packed {
        logic                                  lock;
        logic [LANES-1:0][CORD_BITS-1:0]       vx;
        logic [LANES-1:0][CORD_BITS-1:0]       vy;
        logic [LANES-1:0][ANG_BITS-1:0]        ang;
    } cordic_state_t;

endpackage

[hdl/quaternion_to_euler_zyx_core.sv]
// Top level of the quaternion to Z-Y'-X'' Euler angle converter.
// Depends on qte_pkg, qte_div_cell, qte_sqrt_cell and qte_cordic_cell.
//
// The converter takes one quaternion per cycle while in_stall is low and returns yaw, pitch,
// roll and a gimbal lock flag for each, in order. The path runs through the cell chains: 21
// divider cells for the seven matrix terms, 21 square root cells for cy and 28 CORDIC cells
// shared by the three angles, plus stages of products, sums, selection and rounding and the
// output register. A two-entry output stage lets the chain keep moving while a result waits;
// in_stall rises only when both output entries are full. The gimbal lock threshold is written
// through cfg_write and cfg_data; the user is to write it only while the block is idle, and
// the block itself does not enforce this.
module quaternion_to_euler_zyx_core #(
    parameter int COMPONENT_BITS = 16,
    parameter int ANGLE_BITS     = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic signed [COMPONENT_BITS-1:0] quat_x,
    input  logic signed [COMPONENT_BITS-1:0] quat_y,
    input  logic signed [COMPONENT_BITS-1:0] quat_z,
    input  logic signed [COMPONENT_BITS-1:0] quat_w,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [ANGLE_BITS-1:0]     yaw,
    output logic signed [ANGLE_BITS-1:0]     pitch,
    output logic signed [ANGLE_BITS-1:0]     roll,
    output logic                             gimbal_lock,
    input  logic                             cfg_write,
    input  logic [qte_pkg::THRESH_BITS-1:0]  cfg_data
);

    localparam int DIV_CELLS  = qte_pkg::QUO_BITS;
    localparam int PIPE_DEPTH = 4 + DIV_CELLS + 3 + qte_pkg::SQRT_STEPS + 1
                                + qte_pkg::CORDIC_STEPS + 1;
    localparam int ROUND_SHIFT = qte_pkg::ANG_BITS - ANGLE_BITS;
    localparam logic [qte_pkg::ANG_BITS:0] RND_HALF = (33'd1 << ROUND_SHIFT) >> 1;
    localparam logic signed [qte_pkg::MAT_BITS-1:0] MAT_ONE = 22'sd1 <<< qte_pkg::MAT_FRAC;

    // Product slots.
    localparam int P_XX = 0;
    localparam int P_YY = 1;
    localparam int P_ZZ = 2;
    localparam int P_WW = 3;
    localparam int P_XY = 4;
    localparam int P_WZ = 5;
    localparam int P_YZ = 6;
    localparam int P_WX = 7;
    localparam int P_XZ = 8;
    localparam int P_WY = 9;
    localparam int NUM_PRODS = 10;

    // Component slots.
    localparam int C_X = 0;
    localparam int C_Y = 1;
    localparam int C_Z = 2;
    localparam int C_W = 3;

    logic                              adv;
    logic [PIPE_DEPTH-1:0]             stage_v_reg;
    logic [qte_pkg::THRESH_BITS-1:0]   lock_threshold_reg;

    // Threshold register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lock_threshold_reg <= qte_pkg::THRESH_RESET;
        end
        else if (cfg_write)
        begin
            lock_threshold_reg <= cfg_data;
        end
    end

    // Valid bits move with the chain.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_v_reg <= '0;
        end
        else if (adv)
        begin
            stage_v_reg <= {stage_v_reg[PIPE_DEPTH-2:0], in_valid};
        end
    end

    // Input conversion to the working component width.
    logic signed [COMPONENT_BITS-1:0]     quat_arr [4];
    logic signed [qte_pkg::WORK_BITS-1:0] comp_in  [4];
    logic signed [qte_pkg::WORK_BITS-1:0] comp_a_reg [4];

    assign quat_arr[C_X] = quat_x;
    assign quat_arr[C_Y] = quat_y;
    assign quat_arr[C_Z] = quat_z;
    assign quat_arr[C_W] = quat_w;

    for (genvar g = 0; g < 4; g++)
    begin : g_conv
        if (COMPONENT_BITS >= qte_pkg::WORK_BITS)
        begin : g_cut
            assign comp_in[g] = quat_arr[g][COMPONENT_BITS-1 -: qte_pkg::WORK_BITS];
        end
        else
        begin : g_ext
            assign comp_in[g] = qte_pkg::WORK_BITS'(quat_arr[g]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            comp_a_reg <= comp_in;
        end
    end

    // Component products.
    logic signed [qte_pkg::PROD_BITS-1:0] prod_b_reg [NUM_PRODS];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_b_reg[P_XX] <= comp_a_reg[C_X] * comp_a_reg[C_X];
            prod_b_reg[P_YY] <= comp_a_reg[C_Y] * comp_a_reg[C_Y];
            prod_b_reg[P_ZZ] <= comp_a_reg[C_Z] * comp_a_reg[C_Z];
            prod_b_reg[P_WW] <= comp_a_reg[C_W] * comp_a_reg[C_W];
            prod_b_reg[P_XY] <= comp_a_reg[C_X] * comp_a_reg[C_Y];
            prod_b_reg[P_WZ] <= comp_a_reg[C_W] * comp_a_reg[C_Z];
            prod_b_reg[P_YZ] <= comp_a_reg[C_Y] * comp_a_reg[C_Z];
            prod_b_reg[P_WX] <= comp_a_reg[C_W] * comp_a_reg[C_X];
            prod_b_reg[P_XZ] <= comp_a_reg[C_X] * comp_a_reg[C_Z];
            prod_b_reg[P_WY] <= comp_a_reg[C_W] * comp_a_reg[C_Y];
        end
    end

    // Norm and the seven matrix numerators.
    logic signed [qte_pkg::NUM_BITS-1:0]  pe [NUM_PRODS];
    logic [qte_pkg::NORM_BITS-1:0]        norm_next;
    logic [qte_pkg::NORM_BITS-1:0]        norm_c_reg;
    logic signed [qte_pkg::NUM_BITS-1:0]  num_next  [qte_pkg::NUM_TERMS];
    logic signed [qte_pkg::NUM_BITS-1:0]  num_c_reg [qte_pkg::NUM_TERMS];

    for (genvar g = 0; g < NUM_PRODS; g++)
    begin : g_pext
        assign pe[g] = qte_pkg::NUM_BITS'(prod_b_reg[g]);
    end

    always_comb
    begin
        norm_next = qte_pkg::NORM_BITS'(prod_b_reg[P_XX]) + qte_pkg::NORM_BITS'(prod_b_reg[P_YY])
                  + qte_pkg::NORM_BITS'(prod_b_reg[P_ZZ]) + qte_pkg::NORM_BITS'(prod_b_reg[P_WW]);
        num_next[qte_pkg::T_M00] = pe[P_WW] + pe[P_XX] - pe[P_YY] - pe[P_ZZ];
        num_next[qte_pkg::T_M11] = pe[P_WW] - pe[P_XX] + pe[P_YY] - pe[P_ZZ];
        num_next[qte_pkg::T_M22] = pe[P_WW] - pe[P_XX] - pe[P_YY] + pe[P_ZZ];
        num_next[qte_pkg::T_M10] = (pe[P_XY] + pe[P_WZ]) <<< 1;
        num_next[qte_pkg::T_M12] = (pe[P_YZ] - pe[P_WX]) <<< 1;
        num_next[qte_pkg::T_M20] = (pe[P_XZ] - pe[P_WY]) <<< 1;
        num_next[qte_pkg::T_M21] = (pe[P_YZ] + pe[P_WX]) <<< 1;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            norm_c_reg <= norm_next;
            num_c_reg  <= num_next;
        end
    end

    // Divider set-up: magnitude shifted up with half the divisor added for rounding.
    logic [qte_pkg::NUM_BITS-1:0] mag_d [qte_pkg::NUM_TERMS];
    qte_pkg::div_state_t          div_next;
    qte_pkg::div_state_t          div_chain [DIV_CELLS+1];

    always_comb
    begin
        div_next.den = norm_c_reg;
        div_next.nz  = (norm_c_reg == '0);
        for (int t = 0; t < qte_pkg::NUM_TERMS; t++)
        begin
            div_next.neg[t] = num_c_reg[t][qte_pkg::NUM_BITS-1];
            mag_d[t]        = div_next.neg[t] ? qte_pkg::NUM_BITS'(-num_c_reg[t])
                                              : qte_pkg::NUM_BITS'(num_c_reg[t]);
            div_next.rem[t] = (qte_pkg::DIVD_BITS'(mag_d[t]) << qte_pkg::MAT_FRAC)
                            + qte_pkg::DIVD_BITS'(norm_c_reg >> 1);
            div_next.quo[t] = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            div_chain[0] <= div_next;
        end
    end

    for (genvar j = 0; j < DIV_CELLS; j++)
    begin : g_div
        qte_div_cell #(
            .BIT (DIV_CELLS - 1 - j)
        ) u_cell (
            .clk       (clk),
            .en        (adv),
            .state_in  (div_chain[j]),
            .state_out (div_chain[j+1])
        );
    end

    // Signed matrix terms; a zero quaternion gives the identity.
    logic signed [qte_pkg::MAT_BITS-1:0] mat_next  [qte_pkg::NUM_TERMS];
    logic signed [qte_pkg::MAT_BITS-1:0] mat_e_reg [qte_pkg::NUM_TERMS];
    logic signed [qte_pkg::MAT_BITS-1:0] mat_f_reg [qte_pkg::NUM_TERMS];

    always_comb
    begin
        for (int t = 0; t < qte_pkg::NUM_TERMS; t++)
        begin
            if (div_chain[DIV_CELLS].nz)
            begin
                mat_next[t] = (t <= qte_pkg::T_M22) ? MAT_ONE : '0;
            end
            else if (div_chain[DIV_CELLS].neg[t])
            begin
                mat_next[t] = -$signed({1'b0, div_chain[DIV_CELLS].quo[t]});
            end
            else
            begin
                mat_next[t] = $signed({1'b0, div_chain[DIV_CELLS].quo[t]});
            end
        end
    end

    // Squares of M00 and M10.
    logic signed [2*qte_pkg::MAT_BITS-1:0] sq_prod [2];
    logic [qte_pkg::SQ_BITS-1:0]           sq_f_reg [2];

    assign sq_prod[0] = mat_e_reg[qte_pkg::T_M00] * mat_e_reg[qte_pkg::T_M00];
    assign sq_prod[1] = mat_e_reg[qte_pkg::T_M10] * mat_e_reg[qte_pkg::T_M10];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mat_e_reg   <= mat_next;
            mat_f_reg   <= mat_e_reg;
            sq_f_reg[0] <= sq_prod[0][qte_pkg::SQ_BITS-1:0];
            sq_f_reg[1] <= sq_prod[1][qte_pkg::SQ_BITS-1:0];
        end
    end

    // Square root set-up and chain.
    qte_pkg::sqrt_state_t sqrt_next;
    qte_pkg::sqrt_state_t sqrt_chain [qte_pkg::SQRT_STEPS+1];

    always_comb
    begin
        sqrt_next.rad  = sq_f_reg[0] + sq_f_reg[1];
        sqrt_next.root = '0;
        for (int t = 0; t < qte_pkg::NUM_TERMS; t++)
        begin
            sqrt_next.mat[t] = mat_f_reg[t];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sqrt_chain[0] <= sqrt_next;
        end
    end

    for (genvar j = 0; j < qte_pkg::SQRT_STEPS; j++)
    begin : g_sqrt
        qte_sqrt_cell #(
            .K (qte_pkg::SQRT_STEPS - 1 - j)
        ) u_cell (
            .clk       (clk),
            .en        (adv),
            .state_in  (sqrt_chain[j]),
            .state_out (sqrt_chain[j+1])
        );
    end

    // Lock decision and CORDIC lane set-up.
    logic [qte_pkg::CY_BITS-1:0]          cy_h;
    logic                                 lock_h;
    logic signed [qte_pkg::CORD_BITS-1:0] me [qte_pkg::NUM_TERMS];
    logic signed [qte_pkg::CORD_BITS-1:0] src_x [qte_pkg::LANES];
    logic signed [qte_pkg::CORD_BITS-1:0] src_y [qte_pkg::LANES];
    logic signed [qte_pkg::CORD_BITS-1:0] scl_x [qte_pkg::LANES];
    logic signed [qte_pkg::CORD_BITS-1:0] scl_y [qte_pkg::LANES];
    qte_pkg::cordic_state_t               cord_next;
    qte_pkg::cordic_state_t               cord_chain [qte_pkg::CORDIC_STEPS+1];

    assign cy_h   = sqrt_chain[qte_pkg::SQRT_STEPS].root[qte_pkg::CY_BITS-1:0];
    assign lock_h = (cy_h <= lock_threshold_reg);

    for (genvar g = 0; g < qte_pkg::NUM_TERMS; g++)
    begin : g_mext
        assign me[g] = qte_pkg::CORD_BITS'($signed(sqrt_chain[qte_pkg::SQRT_STEPS].mat[g]));
    end

    always_comb
    begin
        src_y[qte_pkg::L_YAW]   = lock_h ? '0 : me[qte_pkg::T_M10];
        src_x[qte_pkg::L_YAW]   = lock_h ? '0 : me[qte_pkg::T_M00];
        src_y[qte_pkg::L_PITCH] = -me[qte_pkg::T_M20];
        src_x[qte_pkg::L_PITCH] = $signed(qte_pkg::CORD_BITS'(cy_h));
        src_y[qte_pkg::L_ROLL]  = lock_h ? -me[qte_pkg::T_M12] : me[qte_pkg::T_M21];
        src_x[qte_pkg::L_ROLL]  = lock_h ? me[qte_pkg::T_M11] : me[qte_pkg::T_M22];
        cord_next.lock = lock_h;
        for (int l = 0; l < qte_pkg::LANES; l++)
        begin
            scl_x[l] = src_x[l] <<< qte_pkg::CORD_PRESCALE;
            scl_y[l] = src_y[l] <<< qte_pkg::CORD_PRESCALE;
            // A vector in the left half plane is turned by half a turn first.
            if (scl_x[l][qte_pkg::CORD_BITS-1])
            begin
                cord_next.vx[l]  = -scl_x[l];
                cord_next.vy[l]  = -scl_y[l];
                cord_next.ang[l] = qte_pkg::HALF_TURN;
            end
            else
            begin
                cord_next.vx[l]  = scl_x[l];
                cord_next.vy[l]  = scl_y[l];
                cord_next.ang[l] = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cord_chain[0] <= cord_next;
        end
    end

    for (genvar j = 0; j < qte_pkg::CORDIC_STEPS; j++)
    begin : g_cordic
        qte_cordic_cell #(
            .I (j)
        ) u_cell (
            .clk       (clk),
            .en        (adv),
            .state_in  (cord_chain[j]),
            .state_out (cord_chain[j+1])
        );
    end

    // Round the angles to the output width.
    logic [qte_pkg::ANG_BITS:0]  rsum     [qte_pkg::LANES];
    logic [ANGLE_BITS-1:0]       angle_i_reg [qte_pkg::LANES];
    logic                        lock_i_reg;

    for (genvar l = 0; l < qte_pkg::LANES; l++)
    begin : g_round
        assign rsum[l] = {1'b0, cord_chain[qte_pkg::CORDIC_STEPS].ang[l]} + RND_HALF;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int l = 0; l < qte_pkg::LANES; l++)
            begin
                angle_i_reg[l] <= rsum[l][qte_pkg::ANG_BITS-1 -: ANGLE_BITS];
            end
            lock_i_reg <= cord_chain[qte_pkg::CORDIC_STEPS].lock;
        end
    end

    // Output register with a skid entry behind it.
    logic                  out_v_reg;
    logic                  skid_v_reg;
    logic [ANGLE_BITS-1:0] out_ang_reg  [qte_pkg::LANES];
    logic [ANGLE_BITS-1:0] skid_ang_reg [qte_pkg::LANES];
    logic                  out_lock_reg;
    logic                  skid_lock_reg;
    logic                  last_v;

    assign adv      = !skid_v_reg;
    assign in_stall = skid_v_reg;
    assign last_v   = stage_v_reg[PIPE_DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (out_v_reg && out_stall)
        begin
            if (adv && last_v)
            begin
                skid_v_reg <= 1'b1;
            end
        end
        else if (skid_v_reg)
        begin
            out_v_reg  <= 1'b1;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg <= last_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_v_reg && out_stall)
        begin
            if (adv)
            begin
                skid_ang_reg  <= angle_i_reg;
                skid_lock_reg <= lock_i_reg;
            end
        end
        else if (skid_v_reg)
        begin
            out_ang_reg  <= skid_ang_reg;
            out_lock_reg <= skid_lock_reg;
        end
        else
        begin
            out_ang_reg  <= angle_i_reg;
            out_lock_reg <= lock_i_reg;
        end
    end

    assign out_valid   = out_v_reg;
    assign yaw         = $signed(out_ang_reg[qte_pkg::L_YAW]);
    assign pitch       = $signed(out_ang_reg[qte_pkg::L_PITCH]);
    assign roll        = $signed(out_ang_reg[qte_pkg::L_ROLL]);
    assign gimbal_lock = out_lock_reg;

endmodule

[hdl/qte_div_cell.sv]
// One restoring division cell: settles one quotient bit of all seven matrix terms.
// Depends on qte_pkg.
module qte_div_cell #(
    parameter int BIT = 0
) (
    input  logic                clk,
    input  logic                en,
    input  qte_pkg::div_state_t state_in,
    output qte_pkg::div_state_t state_out
);

    qte_pkg::div_state_t               state_next;
    qte_pkg::div_state_t               state_reg;
    logic [qte_pkg::DIVD_BITS-1:0]     trial;

    // Subtract the shifted divisor where it fits and set the quotient bit.
    always_comb
    begin
        state_next = state_in;
        trial      = qte_pkg::DIVD_BITS'(state_in.den) << BIT;
        for (int t = 0; t < qte_pkg::NUM_TERMS; t++)
        begin
            if (state_in.rem[t] >= trial)
            begin
                state_next.rem[t]      = state_in.rem[t] - trial;
                state_next.quo[t][BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            state_reg <= state_next;
        end
    end

    assign state_out = state_reg;

endmodule

[hdl/qte_sqrt_cell.sv]
// One digit-by-digit square root cell: settles one root bit of cy.
// Depends on qte_pkg.
module qte_sqrt_cell #(
    parameter int K = 0
) (
    input  logic                 clk,
    input  logic                 en,
    input  qte_pkg::sqrt_state_t state_in,
    output qte_pkg::sqrt_state_t state_out
);

    qte_pkg::sqrt_state_t        state_next;
    qte_pkg::sqrt_state_t        state_reg;
    logic [qte_pkg::SQ_BITS-1:0] bitv;
    logic [qte_pkg::SQ_BITS-1:0] trial;

    // Try the current power of four against the remaining radicand.
    always_comb
    begin
        state_next = state_in;
        bitv       = qte_pkg::SQ_BITS'(1) << (2 * K);
        trial      = state_in.root + bitv;
        if (state_in.rad >= trial)
        begin
            state_next.rad  = state_in.rad - trial;
            state_next.root = (state_in.root >> 1) + bitv;
        end
        else
        begin
            state_next.root = state_in.root >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            state_reg <= state_next;
        end
    end

    assign state_out = state_reg;

endmodule

[hdl/qte_cordic_cell.sv]
// One CORDIC vectoring cell: one micro-rotation on each of the three angle lanes.
// Depends on qte_pkg.
module qte_cordic_cell #(
    parameter int I = 0
) (
    input  logic                   clk,
    input  logic                   en,
    input  qte_pkg::cordic_state_t state_in,
    output qte_pkg::cordic_state_t state_out
);

    qte_pkg::cordic_state_t              state_next;
    qte_pkg::cordic_state_t              state_reg;
    logic signed [qte_pkg::CORD_BITS-1:0] xs [qte_pkg::LANES];
    logic signed [qte_pkg::CORD_BITS-1:0] ys [qte_pkg::LANES];
    logic signed [qte_pkg::CORD_BITS-1:0] dx [qte_pkg::LANES];
    logic signed [qte_pkg::CORD_BITS-1:0] dy [qte_pkg::LANES];

    // Rotate toward the x axis; a lane whose y has reached zero stays put.
    always_comb
    begin
        state_next = state_in;
        for (int l = 0; l < qte_pkg::LANES; l++)
        begin
            xs[l] = $signed(state_in.vx[l]);
            ys[l] = $signed(state_in.vy[l]);
            dx[l] = xs[l] >>> I;
            dy[l] = ys[l] >>> I;
            if (ys[l] != '0)
            begin
                if (!ys[l][qte_pkg::CORD_BITS-1])
                begin
                    state_next.vx[l]  = xs[l] + dy[l];
                    state_next.vy[l]  = ys[l] - dx[l];
                    state_next.ang[l] = state_in.ang[l] + qte_pkg::ATAN_TURNS[I];
                end
                else
                begin
                    state_next.vx[l]  = xs[l] - dy[l];
                    state_next.vy[l]  = ys[l] + dx[l];
                    state_next.ang[l] = state_in.ang[l] - qte_pkg::ATAN_TURNS[I];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            state_reg <= state_next;
        end
    end

    assign state_out = state_reg;

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for quaternion_to_euler_zyx_core.
// Depends on qte_pkg and the converter RTL; predicts each angle set in SystemVerilog.
module testbench;

    localparam int COMP_W  = 16;
    localparam int ANGLE_W = 16;
    localparam int LATENCY = 79;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] yaw;
        logic signed [ANGLE_W-1:0] pitch;
        logic signed [ANGLE_W-1:0] roll;
        logic                      lock;
    } euler_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [COMP_W-1:0] quat_x, quat_y, quat_z, quat_w;
    logic out_valid;
    logic out_stall;
    logic signed [ANGLE_W-1:0] yaw, pitch, roll;
    logic gimbal_lock;
    logic cfg_write;
    logic [qte_pkg::THRESH_BITS-1:0] cfg_data;

    // Model copy of the threshold register and the queue of predicted angle sets.
    logic [qte_pkg::THRESH_BITS-1:0] lock_limit;
    euler_t angles_due[$];
    int mismatches;
    int send_idle_pct;
    int recv_stall_pct;

    quaternion_to_euler_zyx_core #(
        .COMPONENT_BITS(COMP_W),
        .ANGLE_BITS    (ANGLE_W)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .quat_x     (quat_x),
        .quat_y     (quat_y),
        .quat_z     (quat_z),
        .quat_w     (quat_w),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .yaw        (yaw),
        .pitch      (pitch),
        .roll       (roll),
        .gimbal_lock(gimbal_lock),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Floor shift of a signed value.
    function automatic longint fshr(longint v, int k);
        return v >>> k;
    endfunction

    // Matrix term: num/den times 2^20, rounded with ties away from zero.
    function automatic longint ratio_q20(longint num, longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = ((mag <<< qte_pkg::MAT_FRAC) + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint floor_sqrt(longint v);
        longint res;
        longint b;
        res = 0;
        b = 64'sd1 <<< 62;
        while (b > v) b = b >>> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >>> 1) + b;
            end
            else
                res = res >>> 1;
            b = b >>> 2;
        end
        return res;
    endfunction

    // Vectoring CORDIC with a 32-bit binary angle.
    function automatic logic [31:0] vec_angle(longint y, longint x);
        logic [31:0] a;
        longint dx;
        longint dy;
        a = '0;
        if (x == 0 && y == 0) return '0;
        x = x * 256;
        y = y * 256;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            a = qte_pkg::HALF_TURN;
        end
        for (int i = 0; i < qte_pkg::CORDIC_STEPS; i++)
        begin
            if (y == 0) break;
            dx = fshr(x, i);
            dy = fshr(y, i);
            if (y > 0)
            begin
                x = x + dy;
                y = y - dx;
                a = a + qte_pkg::ATAN_TURNS[i];
            end
            else
            begin
                x = x - dy;
                y = y + dx;
                a = a - qte_pkg::ATAN_TURNS[i];
            end
        end
        return a;
    endfunction

    function automatic logic [ANGLE_W-1:0] round_angle(logic [31:0] a);
        logic [32:0] t;
        t = {1'b0, a} + (33'd1 << (32 - ANGLE_W - 1));
        return t[31 -: ANGLE_W];
    endfunction

    function automatic euler_t euler_of(longint x, longint y, longint z, longint w);
        euler_t r;
        longint n;
        longint m00, m10, m11, m12, m20, m21, m22;
        longint cy;
        logic locked;
        n = x * x + y * y + z * z + w * w;
        if (n == 0)
        begin
            m00 = 64'sd1 <<< qte_pkg::MAT_FRAC;
            m11 = m00;
            m22 = m00;
            m10 = 0; m12 = 0; m20 = 0; m21 = 0;
        end
        else
        begin
            m00 = ratio_q20(w * w + x * x - y * y - z * z, n);
            m11 = ratio_q20(w * w - x * x + y * y - z * z, n);
            m22 = ratio_q20(w * w - x * x - y * y + z * z, n);
            m10 = ratio_q20(2 * (x * y + w * z), n);
            m12 = ratio_q20(2 * (y * z - w * x), n);
            m20 = ratio_q20(2 * (x * z - w * y), n);
            m21 = ratio_q20(2 * (y * z + w * x), n);
        end
        cy = floor_sqrt(m00 * m00 + m10 * m10);
        locked = (cy <= longint'(lock_limit));
        r.pitch = round_angle(vec_angle(-m20, cy));
        if (locked)
        begin
            r.roll = round_angle(vec_angle(-m12, m11));
            r.yaw = '0;
        end
        else
        begin
            r.roll = round_angle(vec_angle(m21, m22));
            r.yaw = round_angle(vec_angle(m10, m00));
        end
        r.lock = locked;
        return r;
    endfunction

    // Sends one quaternion and predicts its angles at the transfer.
    // Valid stays high afterwards so that the next item can follow at once.
    task automatic send_quat(logic [15:0] x, logic [15:0] y, logic [15:0] z, logic [15:0] w);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        quat_x <= x;
        quat_y <= y;
        quat_z <= z;
        quat_w <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        angles_due.push_back(euler_of($signed(x), $signed(y), $signed(z), $signed(w)));
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (angles_due.size() != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    task automatic set_threshold(logic [qte_pkg::THRESH_BITS-1:0] v);
        cfg_write <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        lock_limit = v;
    endtask

    // Receiver stall, redrawn every cycle.
    always @(posedge clk)
        out_stall <= ($urandom_range(99, 0) < recv_stall_pct);

    // Compares each output transfer with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            euler_t got;
            euler_t want;
            got = {yaw, pitch, roll, gimbal_lock};
            if (angles_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end
            else
            begin
                want = angles_due.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp y=%0d p=%0d r=%0d l=%0b got y=%0d p=%0d r=%0d l=%0b",
                                 want.yaw, want.pitch, want.roll, want.lock,
                                 got.yaw, got.pitch, got.roll, got.lock);
                end
            end
        end
    end

    task automatic test_directed;
        logic [15:0] ext [6];
        ext = '{16'h8000, 16'h7fff, 16'h0000, 16'h4000, 16'hc000, 16'h0001};
        send_quat(0, 0, 0, 0);
        send_quat(0, 0, 0, 16'h4000);
        send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_quat(16'h8000, 0, 0, 0);
        send_quat(0, 0, 16'h4000, 0);
        // Pitch of plus or minus ninety degrees: gimbal lock.
        send_quat(0, 16'h2d41, 0, 16'h2d41);
        send_quat(0, 16'hd2bf, 0, 16'h2d41);
        send_quat(16'h1000, 16'h2000, 16'h1000, 16'h2000);
        send_quat(16'h7fff, 16'h8000, 16'h0001, 16'hffff);
        for (int i = 0; i < 12; i++)
            send_quat(ext[$urandom_range(5, 0)], ext[$urandom_range(5, 0)],
                      ext[$urandom_range(5, 0)], ext[$urandom_range(5, 0)]);
    endtask

    task automatic test_random(int count);
        logic [15:0] a, b;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(3, 0))
                0: begin
                    // Near gimbal lock: y = +-w, z = x plus a small offset.
                    a = 16'($urandom);
                    b = 16'($urandom);
                    send_quat(b, a, b + 16'($urandom_range(3, 0)),
                              $urandom_range(1, 0) ? a : -a);
                end
                1: send_quat(16'($urandom_range(15, 0) - 8), 16'($urandom_range(15, 0) - 8),
                             16'($urandom_range(15, 0) - 8), 16'($urandom_range(15, 0) - 8));
                default: send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            endcase
        end
    endtask

    task automatic test_thresholds;
        logic [qte_pkg::THRESH_BITS-1:0] lims [4];
        lims = '{21'd0, 21'd1048576, 21'h1fffff, 21'd40000};
        foreach (lims[i])
        begin
            drain();
            set_threshold(lims[i]);
            send_quat(0, 0, 0, 0);
            send_quat(0, 16'h2d41, 0, 16'h2d41);
            test_random(40);
        end
        drain();
        set_threshold(qte_pkg::THRESH_RESET);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        quat_x = '0; quat_y = '0; quat_z = '0; quat_w = '0;
        out_stall = 1'b0;
        cfg_write = 1'b0;
        cfg_data = '0;
        lock_limit = qte_pkg::THRESH_RESET;
        mismatches = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        // Hold off until the pipeline is empty before going on.
        drain();
        test_random(250);
        send_idle_pct = 88;
        test_random(200);
        send_idle_pct = 0;
        recv_stall_pct = 88;
        test_random(200);
        send_idle_pct = 18;
        recv_stall_pct = 18;
        test_random(250);
        test_thresholds();
        drain();
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
